/* hdl/tcpfc_pkg.sv */
// Shared types, constants and frame helpers for the timed cover position
// frame controller. No dependencies; every file but the divider imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tcpfc_pkg;

    // Field widths fixed by the interface
    localparam int POSITION_BITS_DEF = 16;
    localparam int CMD_W      = 3;
    localparam int ELAPSED_W  = 16;
    localparam int TPOS_W     = 16;
    localparam int POS_OUT_W  = 16;
    localparam int DUR_W      = 22;
    localparam int NODE_W     = 24;
    localparam int CH_W       = 8;
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam logic [DUR_W-1:0] DUR_RESET = 22'd10000;

    // Frame bytes
    localparam logic [7:0] HDR_MOVE0      = 8'h7F;
    localparam logic [7:0] HDR_MOVE1      = 8'hF2;
    localparam logic [7:0] HDR_TILT0      = 8'h7E;
    localparam logic [7:0] HDR_TILT1      = 8'hF1;
    localparam logic [7:0] BYTE_FA        = 8'hFA;
    localparam logic [7:0] BYTE_01        = 8'h01;
    localparam logic [7:0] BYTE_00        = 8'h00;
    localparam logic [7:0] CODE_STOP      = 8'hFC;
    localparam logic [7:0] CODE_OPEN      = 8'hFE;
    localparam logic [7:0] CODE_CLOSE     = 8'hFD;
    localparam logic [7:0] CODE_TILT_UP   = 8'hFF;
    localparam logic [7:0] CODE_TILT_DOWN = 8'hFE;
    localparam logic [7:0] BYTE_TILT_TAIL = 8'hFE;

    localparam logic [IDX_W-1:0] LEN_NONE = 4'd1;
    localparam logic [IDX_W-1:0] LEN_MOVE = 4'd13;
    localparam logic [IDX_W-1:0] LEN_TILT = 4'd14;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_TOGGLE = 3'd2,
        CMD_SETPOS = 3'd3,
        CMD_TILT   = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID    = 3'd0,
        CFG_CHANNEL    = 3'd1,
        CFG_OPEN_TIME  = 3'd2,
        CFG_CLOSE_TIME = 3'd3,
        CFG_INVERTED   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOT_IDLE  = 2'd0,
        MOT_OPEN  = 2'd1,
        MOT_CLOSE = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        FK_NONE = 2'd0,
        FK_MOVE = 2'd1,
        FK_TILT = 2'd2
    } t_frame_kind;

    typedef enum logic [1:0] {
        TGT_TPOS = 2'd0,
        TGT_MAX  = 2'd1,
        TGT_ZERO = 2'd2
    } t_tgt_sel;

    // Controller to datapath
    typedef struct packed {
        logic        load_in;
        logic        div_start;
        logic        pos_update;
        logic        tgt_we;
        t_tgt_sel    tgt_sel;
        logic        mot_we;
        t_motion     mot_val;
        logic        ldir_we;
        logic        frm_start;
        t_frame_kind frm_kind;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd_code;
        t_motion          motion;
        logic             last_close;
        logic             pos_zero;
        logic             tpos_eq;
        logic             tpos_lt;
        logic             tpos_zero;
        logic             tpos_max;
        logic             at_target;
        logic             tgt_end;
        logic             div_busy;
        logic             gen_busy;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] frame_len(input t_frame_kind kind);
        logic [IDX_W-1:0] len;
        case (kind)
            FK_MOVE: len = LEN_MOVE;
            FK_TILT: len = LEN_TILT;
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

    // Frame body byte at a position ahead of the checksum
    function automatic logic [7:0] frame_body(
        input t_frame_kind       kind,
        input logic [IDX_W-1:0]  idx,
        input logic [7:0]        code,
        input logic [NODE_W-1:0] node,
        input logic [CH_W-1:0]   ch
    );
        logic [7:0] b;
        case (idx)
            4'd0:    b = (kind == FK_TILT) ? HDR_TILT0 : HDR_MOVE0;
            4'd1:    b = (kind == FK_TILT) ? HDR_TILT1 : HDR_MOVE1;
            4'd2:    b = BYTE_FA;
            4'd3:    b = BYTE_01;
            4'd4:    b = BYTE_00;
            4'd5:    b = BYTE_00;
            4'd6:    b = ~node[7:0];
            4'd7:    b = ~node[15:8];
            4'd8:    b = ~node[23:16];
            4'd9:    b = ~ch;
            4'd10:   b = code;
            4'd11:   b = BYTE_TILT_TAIL;
            default: b = BYTE_00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hdl/tcpfc_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module tcpfc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 22
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_nq;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;
    logic           ge;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        rem_sh = {r_rem, r_nq[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Numerator bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_nq  <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_nq  <= {r_nq[NUM_W-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_nq;

endmodule

`default_nettype wire

/* hdl/tcpfc_dp.sv */
// Datapath: configuration, position/target/motion registers, tick divider,
// frame byte generator with running checksum, output word register. Uses tcpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpfc_dp #(
    parameter int POSITION_BITS = tcpfc_pkg::POSITION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tcpfc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [tcpfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [tcpfc_pkg::CMD_W-1:0]     i_cmd_code,
    input  wire logic [tcpfc_pkg::ELAPSED_W-1:0] i_elapsed,
    input  wire logic [tcpfc_pkg::TPOS_W-1:0]    i_tpos,
    input  wire logic                            i_tilt_up,
    input  wire tcpfc_pkg::t_dp_cmd              i_ctl,
    output tcpfc_pkg::t_dp_status                o_status,
    input  wire logic                            i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [tcpfc_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast,
    output logic [tcpfc_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    import tcpfc_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int NUM_W = ELAPSED_W + PB;
    localparam logic [PB-1:0] POS_MAX   = {PB{1'b1}};
    localparam logic [PB-1:0] POS_HALF  = {1'b1, {(PB-1){1'b0}}};
    localparam int PAD_W = M_TDATA_W - BYTE_W - POS_OUT_W - 2;

    // Configuration
    logic [NODE_W-1:0] r_node;
    logic [CH_W-1:0]   r_ch;
    logic [DUR_W-1:0]  r_open_t;
    logic [DUR_W-1:0]  r_close_t;
    logic              r_inv;

    // Latched input word
    logic [CMD_W-1:0]     r_cmd;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [PB-1:0]        r_tpos;
    logic                 r_tilt;

    // Cover state
    logic [PB-1:0] r_pos;
    logic [PB-1:0] r_tgt;
    t_motion       r_mot;
    t_motion       r_ldir;

    // Frame generator
    logic              r_gen_act;
    t_frame_kind       r_kind;
    logic [7:0]        r_code;
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;

    // Output word
    logic                 r_valid;
    logic [BYTE_W-1:0]    r_byte;
    logic                 r_has;
    logic                 r_last;
    logic [POS_OUT_W-1:0] r_pnow;
    t_motion              r_pmot;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node    <= '0;
            r_ch      <= '0;
            r_open_t  <= DUR_RESET;
            r_close_t <= DUR_RESET;
            r_inv     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NODE_ID:    r_node    <= i_cfg_data[NODE_W-1:0];
                CFG_CHANNEL:    r_ch      <= i_cfg_data[CH_W-1:0];
                CFG_OPEN_TIME:  r_open_t  <= i_cfg_data[DUR_W-1:0];
                CFG_CLOSE_TIME: r_close_t <= i_cfg_data[DUR_W-1:0];
                CFG_INVERTED:   r_inv     <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Capture the accepted input word; target is masked to the position width
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd     <= i_cmd_code;
            r_elapsed <= i_elapsed;
            r_tpos    <= PB'(i_tpos);
            r_tilt    <= i_tilt_up;
        end
    end

    // Tick division: elapsed * POS_MAX / travel time
    logic [DUR_W-1:0] dur_sel;
    logic [DUR_W-1:0] div_den;
    logic [NUM_W-1:0] div_num;
    logic             div_busy;
    logic [NUM_W-1:0] quot;

    always_comb begin
        dur_sel = (r_mot == MOT_OPEN) ? r_open_t : r_close_t;
        div_den = (dur_sel == '0) ? DUR_W'(1) : dur_sel;
        div_num = {r_elapsed, {PB{1'b0}}} - {{PB{1'b0}}, r_elapsed};
    end

    tcpfc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DUR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // Advance and clamp the position in the current direction
    logic [NUM_W:0]  sum_open;
    logic [PB-1:0]   pos_open;
    logic [PB-1:0]   pos_close;
    logic [PB-1:0]   pos_tick;

    always_comb begin
        sum_open  = {1'b0, NUM_W'(r_pos)} + {1'b0, quot};
        pos_open  = (sum_open > {1'b0, NUM_W'(POS_MAX)}) ? POS_MAX : sum_open[PB-1:0];
        pos_close = (quot >= NUM_W'(r_pos)) ? '0 : (r_pos - quot[PB-1:0]);
        pos_tick  = (r_mot == MOT_OPEN) ? pos_open : pos_close;
    end

    logic [PB-1:0] tgt_next;

    always_comb begin
        case (i_ctl.tgt_sel)
            TGT_MAX:  tgt_next = POS_MAX;
            TGT_ZERO: tgt_next = '0;
            default:  tgt_next = r_tpos;
        endcase
    end

    // Hold cover state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HALF;
            r_tgt  <= '0;
            r_mot  <= MOT_IDLE;
            r_ldir <= MOT_IDLE;
        end else begin
            if (i_ctl.pos_update) begin
                r_pos <= pos_tick;
            end
            if (i_ctl.tgt_we) begin
                r_tgt <= tgt_next;
            end
            if (i_ctl.mot_we) begin
                r_mot <= i_ctl.mot_val;
            end
            if (i_ctl.ldir_we) begin
                r_ldir <= i_ctl.mot_val;
            end
        end
    end

    // Pick the command code when a frame starts
    logic [7:0] code_next;

    always_comb begin
        if (i_ctl.frm_kind == FK_TILT) begin
            code_next = r_tilt ? CODE_TILT_UP : CODE_TILT_DOWN;
        end else begin
            case (i_ctl.mot_val)
                MOT_OPEN:  code_next = r_inv ? CODE_CLOSE : CODE_OPEN;
                MOT_CLOSE: code_next = r_inv ? CODE_OPEN : CODE_CLOSE;
                default:   code_next = CODE_STOP;
            endcase
        end
    end

    // Current frame byte: body, then checksum high and low
    logic [IDX_W-1:0] gen_len;
    logic [7:0]       body;
    logic             is_ckh;
    logic             is_ckl;
    logic             gen_last;
    logic [7:0]       gen_byte;
    logic             gen_load;

    always_comb begin
        gen_len  = frame_len(r_kind);
        body     = frame_body(r_kind, r_idx, r_code, r_node, r_ch);
        gen_last = (r_idx == gen_len - 1'b1);
        is_ckl   = (r_kind != FK_NONE) && gen_last;
        is_ckh   = (r_kind != FK_NONE) && (r_idx == gen_len - 4'd2);
        if (r_kind == FK_NONE) begin
            gen_byte = BYTE_00;
        end else if (is_ckl) begin
            gen_byte = r_sum[7:0];
        end else if (is_ckh) begin
            gen_byte = r_sum[15:8];
        end else begin
            gen_byte = body;
        end
        gen_load = r_gen_act && (!r_valid || i_m_tready);
    end

    // Step the generator one word per free output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_act <= 1'b0;
        end else if (i_ctl.frm_start) begin
            r_gen_act <= 1'b1;
        end else if (gen_load && gen_last) begin
            r_gen_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.frm_start) begin
            r_kind <= i_ctl.frm_kind;
            r_code <= code_next;
            r_idx  <= '0;
            r_sum  <= '0;
        end else if (gen_load) begin
            r_idx <= r_idx + 1'b1;
            if (!is_ckh && !is_ckl) begin
                r_sum <= r_sum + {8'h00, body};
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (gen_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_load) begin
            r_byte <= gen_byte;
            r_has  <= (r_kind != FK_NONE);
            r_last <= gen_last;
            r_pnow <= POS_OUT_W'(r_pos);
            r_pmot <= r_mot;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_pmot, r_pnow, r_byte};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_has;

    // Status toward the controller
    always_comb begin
        o_status.cmd_code   = r_cmd;
        o_status.motion     = r_mot;
        o_status.last_close = (r_ldir == MOT_CLOSE);
        o_status.pos_zero   = (r_pos == '0);
        o_status.tpos_eq    = (r_tpos == r_pos);
        o_status.tpos_lt    = (r_tpos < r_pos);
        o_status.tpos_zero  = (r_tpos == '0);
        o_status.tpos_max   = (r_tpos == POS_MAX);
        o_status.at_target  = (r_mot == MOT_OPEN) ? (r_pos >= r_tgt) : (r_pos <= r_tgt);
        o_status.tgt_end    = (r_tgt == '0) || (r_tgt == POS_MAX);
        o_status.div_busy   = div_busy;
        o_status.gen_busy   = r_gen_act;
    end

endmodule

`default_nettype wire

/* hdl/tcpfc_ctrl.sv */
// Controller: decodes each accepted command word and sequences the datapath
// through division, position check and frame output. Uses tcpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpfc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_valid,
    output logic                       o_s_ready,
    input  wire tcpfc_pkg::t_dp_status i_status,
    output tcpfc_pkg::t_dp_cmd         o_ctl
);

    import tcpfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Start a move or stop; a move already in progress only keeps going
    function automatic t_dp_cmd with_dir(input t_dp_cmd c, input t_motion dir,
                                         input t_motion cur);
        t_dp_cmd r;
        r = c;
        r.frm_start = 1'b1;
        if (dir == cur && dir != MOT_IDLE) begin
            r.frm_kind = FK_NONE;
        end else begin
            r.mot_we   = 1'b1;
            r.mot_val  = dir;
            r.ldir_we  = (dir != MOT_IDLE);
            r.frm_kind = FK_MOVE;
        end
        return r;
    endfunction

    always_comb begin
        t_dp_cmd c;
        c       = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid && o_s_ready) begin
                    c.load_in = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                case (i_status.cmd_code)
                    CMD_TICK: begin
                        if (i_status.motion == MOT_IDLE) begin
                            c.frm_start = 1'b1;
                            c.frm_kind  = FK_NONE;
                        end else begin
                            c.div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                    CMD_STOP: begin
                        c = with_dir(c, MOT_IDLE, i_status.motion);
                    end
                    CMD_TOGGLE: begin
                        if (i_status.motion != MOT_IDLE) begin
                            c = with_dir(c, MOT_IDLE, i_status.motion);
                        end else if (i_status.pos_zero || i_status.last_close) begin
                            c.tgt_we  = 1'b1;
                            c.tgt_sel = TGT_MAX;
                            c = with_dir(c, MOT_OPEN, i_status.motion);
                        end else begin
                            c.tgt_we  = 1'b1;
                            c.tgt_sel = TGT_ZERO;
                            c = with_dir(c, MOT_CLOSE, i_status.motion);
                        end
                    end
                    CMD_SETPOS: begin
                        if (i_status.tpos_eq) begin
                            if (i_status.tpos_zero || i_status.tpos_max) begin
                                c.tgt_we  = 1'b1;
                                c.tgt_sel = TGT_TPOS;
                                c = with_dir(c, i_status.tpos_zero ? MOT_CLOSE : MOT_OPEN,
                                             i_status.motion);
                            end else begin
                                c.frm_start = 1'b1;
                                c.frm_kind  = FK_NONE;
                            end
                        end else begin
                            c.tgt_we  = 1'b1;
                            c.tgt_sel = TGT_TPOS;
                            c = with_dir(c, i_status.tpos_lt ? MOT_CLOSE : MOT_OPEN,
                                         i_status.motion);
                        end
                    end
                    CMD_TILT: begin
                        c.frm_start = 1'b1;
                        c.frm_kind  = FK_TILT;
                    end
                    default: begin
                        c.frm_start = 1'b1;
                        c.frm_kind  = FK_NONE;
                    end
                endcase
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    c.pos_update = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_EMIT;
                if (i_status.at_target && i_status.tgt_end) begin
                    c.mot_we    = 1'b1;
                    c.mot_val   = MOT_IDLE;
                    c.frm_start = 1'b1;
                    c.frm_kind  = FK_NONE;
                end else if (i_status.at_target) begin
                    c = with_dir(c, MOT_IDLE, i_status.motion);
                end else begin
                    c.frm_start = 1'b1;
                    c.frm_kind  = FK_NONE;
                end
            end
            S_EMIT: begin
                if (!i_status.gen_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_ctl = c;
    end

    // Hold state and the registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            o_s_ready <= 1'b0;
        end else begin
            r_state   <= n_state;
            o_s_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

/* hdl/timed_cover_position_frame_controller_top.sv */
// Timed cover position frame controller top: controller plus datapath, uses tcpfc_pkg.
// After accept the controller decodes the word and starts the frame generator, which gives
// one word a cycle while the output is not stalled (13 or 14, or one empty word); a moving
// tick first runs the divider, then updates and checks the position. A new word is taken
// only once the previous frame is fully queued. Reset: synchronous active low; half-open
// position, idle, registers to defaults; input ready rises in the cycle after reset release.
`timescale 1ns / 1ps
`default_nettype none

module timed_cover_position_frame_controller_top #(
    parameter int POSITION_BITS = tcpfc_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tcpfc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [tcpfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command stream in
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: elapsed_ms[15:0], target_position[31:16], tilt_up[32], zero pad
    input  wire logic [tcpfc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[2:0]
    input  wire logic [tcpfc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // frame word stream out
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: frame_byte[7:0], position_now[23:8], motion[25:24], zero pad
    output logic [tcpfc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast,
    // tuser: has_byte[0]
    output logic [tcpfc_pkg::M_TUSER_W-1:0]       m_axis_tuser
);

    import tcpfc_pkg::*;

    t_dp_cmd    w_ctl;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    tcpfc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (w_status),
        .o_ctl     (w_ctl)
    );

    tcpfc_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd_code (s_axis_tuser[CMD_W-1:0]),
        .i_elapsed  (s_axis_tdata[ELAPSED_W-1:0]),
        .i_tpos     (s_axis_tdata[ELAPSED_W+TPOS_W-1:ELAPSED_W]),
        .i_tilt_up  (s_axis_tdata[ELAPSED_W+TPOS_W]),
        .i_ctl      (w_ctl),
        .o_status   (w_status),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // A new word is only taken once the previous frame is fully queued
    a_accept_gen_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !w_status.gen_busy)
        else $error("input accepted while frame generator busy");

    // A frame never starts over a running frame or division
    a_frame_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.frm_start |-> (!w_status.gen_busy && !w_status.div_busy))
        else $error("frame started while generator or divider busy");

    // Division only runs while the cover moves
    a_div_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.div_start |-> (w_status.motion == MOT_OPEN || w_status.motion == MOT_CLOSE))
        else $error("divider started while idle");

    // Position is updated only right after the divider finishes
    a_update_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pos_update |-> $past(w_status.div_busy))
        else $error("position updated without a finished division");
`endif

endmodule

`default_nettype wire

/* bench/timed_cover_position_frame_controller_top_test.sv */
// Self-checking bench for timed_cover_position_frame_controller_top: a directed table, then
// random command streams, each word scored against typed rows or a cover/frame predictor.
// Depends on tcpfc_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module timed_cover_position_frame_controller_top_test;
    import tcpfc_pkg::*;

    // Spare command codes the block must ignore
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam logic [15:0] POS_HALF = 16'h8000;
    localparam logic [15:0] POS_FULL = 16'hFFFF;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 96;
    localparam int REPORT_FIRST = 10;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  fbyte;
        logic        last;
        logic [15:0] pos;
        logic [1:0]  mot;
    } t_cover_word;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] elapsed;
        logic [15:0] tpos;
        logic        tilt;
        logic        typed;
        logic [15:0] exp_pos;
        logic [1:0]  exp_mot;
    } t_plan_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    timed_cover_position_frame_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state and register shadow
    logic [15:0] pos_q;
    logic [15:0] tgt_q;
    t_motion     mot_q;
    t_motion     ldir_q;
    logic [23:0] node_q;
    logic [7:0]  ch_q;
    logic [21:0] open_q;
    logic [21:0] close_q;
    logic        inv_q;
    logic [7:0]  frm [0:13];
    int          frm_len;

    t_cover_word step_words[$];
    t_cover_word expected_frame_words[$];
    t_plan_row   directed_plan[$];

    int  snd_idle_pct = 23;
    int  rcv_idle_pct = 51;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    bit  run_active   = 1'b0;
    int  stall_cycles = 0;
    int  mismatches   = 0;

    function automatic t_cover_word word_of(input logic hb, input logic [7:0] b,
                                            input logic l, input logic [15:0] p,
                                            input logic [1:0] m);
        word_of = {hb, b, l, p, m};
    endfunction

    // Fill the frame buffer: header, fixed bytes, inverted address, code, tilt tail, byte-sum
    function automatic void load_frame(input bit tilt, input logic [7:0] code);
        logic [15:0] sum;
        int          n;
        n       = tilt ? 14 : 13;
        frm[0]  = tilt ? HDR_TILT0 : HDR_MOVE0;
        frm[1]  = tilt ? HDR_TILT1 : HDR_MOVE1;
        frm[2]  = BYTE_FA;
        frm[3]  = BYTE_01;
        frm[4]  = BYTE_00;
        frm[5]  = BYTE_00;
        frm[6]  = ~node_q[7:0];
        frm[7]  = ~node_q[15:8];
        frm[8]  = ~node_q[23:16];
        frm[9]  = ~ch_q;
        frm[10] = code;
        if (tilt) begin
            frm[11] = BYTE_TILT_TAIL;
        end
        sum = '0;
        for (int i = 0; i < n - 2; i++) begin
            sum = sum + frm[i];
        end
        frm[n-2] = sum[15:8];
        frm[n-1] = sum[7:0];
        frm_len  = n;
    endfunction

    // Start a move or stop; a move already under way loads no frame
    function automatic void head_to(input t_motion dir);
        logic [7:0] code;
        if (dir == mot_q && dir != MOT_IDLE) begin
            return;
        end
        if (dir == MOT_OPEN) begin
            code   = inv_q ? CODE_CLOSE : CODE_OPEN;
            ldir_q = dir;
        end else if (dir == MOT_CLOSE) begin
            code   = inv_q ? CODE_OPEN : CODE_CLOSE;
            ldir_q = dir;
        end else begin
            code = CODE_STOP;
        end
        mot_q = dir;
        load_frame(1'b0, code);
    endfunction

    // Advance the position estimate by elapsed time and test the target
    function automatic void run_tick(input logic [15:0] elapsed);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] delta;
        logic [63:0] sum;
        bit          reached;
        if (mot_q != MOT_OPEN && mot_q != MOT_CLOSE) begin
            return;
        end
        den = (mot_q == MOT_OPEN) ? 64'(open_q) : 64'(close_q);
        if (den == 0) begin
            den = 1;
        end
        num   = 64'(elapsed);
        delta = (num * 64'd65535) / den;
        if (mot_q == MOT_OPEN) begin
            sum     = pos_q + delta;
            pos_q   = (sum > POS_FULL) ? POS_FULL : sum[15:0];
            reached = (pos_q >= tgt_q);
        end else begin
            pos_q   = (delta >= pos_q) ? 16'd0 : pos_q - delta[15:0];
            reached = (pos_q <= tgt_q);
        end
        if (reached) begin
            if (tgt_q == 16'd0 || tgt_q == POS_FULL) begin
                mot_q = MOT_IDLE;
            end else begin
                head_to(MOT_IDLE);
            end
        end
    endfunction

    // Apply one command to the predictor and list the words it should produce
    function automatic void advance_cover(input logic [2:0] cmd, input logic [15:0] elapsed,
                                          input logic [15:0] tpos, input logic tilt);
        frm_len = 0;
        case (cmd)
            CMD_TICK: begin
                run_tick(elapsed);
            end
            CMD_STOP: begin
                head_to(MOT_IDLE);
            end
            CMD_TOGGLE: begin
                if (mot_q != MOT_IDLE) begin
                    head_to(MOT_IDLE);
                end else if (pos_q == 16'd0 || ldir_q == MOT_CLOSE) begin
                    tgt_q = POS_FULL;
                    head_to(MOT_OPEN);
                end else begin
                    tgt_q = 16'd0;
                    head_to(MOT_CLOSE);
                end
            end
            CMD_SETPOS: begin
                if (tpos != pos_q || tpos == 16'd0 || tpos == POS_FULL) begin
                    tgt_q = tpos;
                    if (tpos == pos_q) begin
                        if (tpos == 16'd0) begin
                            head_to(MOT_CLOSE);
                        end else begin
                            head_to(MOT_OPEN);
                        end
                    end else if (tpos < pos_q) begin
                        head_to(MOT_CLOSE);
                    end else begin
                        head_to(MOT_OPEN);
                    end
                end
            end
            CMD_TILT: begin
                load_frame(1'b1, tilt ? CODE_TILT_UP : CODE_TILT_DOWN);
            end
            default: begin
            end
        endcase
        step_words.delete();
        if (frm_len == 0) begin
            step_words.push_back(word_of(1'b0, 8'h00, 1'b1, pos_q, mot_q));
        end else begin
            for (int k = 0; k < frm_len; k++) begin
                step_words.push_back(word_of(1'b1, frm[k], k == frm_len - 1, pos_q, mot_q));
            end
        end
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [15:0] el,
                                    input logic [15:0] tp, input logic tl, input logic typed,
                                    input logic [15:0] exp_pos, input t_motion exp_mot);
        directed_plan.push_back({cmd, el, tp, tl, typed, exp_pos, exp_mot});
    endfunction

    // Offer one command word, with random gaps, and book its expected output on accept
    task automatic send_command(input logic [2:0] cmd, input logic [15:0] el,
                                input logic [15:0] tp, input logic tl, input logic typed,
                                input logic [15:0] exp_pos, input logic [1:0] exp_mot);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tl, tp, el};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_cover(cmd, el, tp, tl);
        if (typed) begin
            expected_frame_words.push_back(word_of(1'b0, 8'h00, 1'b1, exp_pos, exp_mot));
        end else begin
            foreach (step_words[k]) begin
                expected_frame_words.push_back(step_words[k]);
            end
        end
    endtask

    // Drop the command valid and wait for every booked word to come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_frame_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NODE_ID:    node_q  = val;
            CFG_CHANNEL:    ch_q    = val[7:0];
            CFG_OPEN_TIME:  open_q  = val[21:0];
            CFG_CLOSE_TIME: close_q = val[21:0];
            CFG_INVERTED:   inv_q   = val[0];
            default: begin
            end
        endcase
    endtask

    // Reprogram all registers once the block has gone quiet
    task automatic set_regs(input logic [23:0] node, input logic [7:0] ch,
                            input logic [21:0] ot, input logic [21:0] ct, input logic inv);
        drain();
        write_reg(CFG_NODE_ID, node);
        write_reg(CFG_CHANNEL, {16'd0, ch});
        write_reg(CFG_OPEN_TIME, {2'd0, ot});
        write_reg(CFG_CLOSE_TIME, {2'd0, ct});
        write_reg(CFG_INVERTED, {23'd0, inv});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_target();
        int s;
        s = $urandom_range(9);
        if (s < 2) begin
            return 16'd0;
        end else if (s < 4) begin
            return POS_FULL;
        end else if (s == 4) begin
            return pos_q;
        end
        return 16'($urandom);
    endfunction

    // Mostly well-formed moves: start a move, then ticks sized to the travel time
    task automatic pick_item(output logic [2:0] cmd, output logic [15:0] el,
                             output logic [15:0] tp, output logic tl);
        int          r;
        int unsigned hi;
        el = 16'($urandom);
        tp = 16'($urandom);
        tl = 1'($urandom);
        r  = $urandom_range(99);
        if (mot_q != MOT_IDLE) begin
            if (r < 72) begin
                cmd = CMD_TICK;
                hi  = (mot_q == MOT_OPEN) ? 32'(open_q) : 32'(close_q);
                if (hi == 0) begin
                    hi = 1;
                end
                hi = hi / $urandom_range(40, 3);
                if (hi > 65535) begin
                    hi = 65535;
                end
                if (hi == 0) begin
                    hi = 1;
                end
                if (r < 64) begin
                    el = 16'($urandom_range(hi, 0));
                end
            end else if (r < 80) begin
                cmd = CMD_STOP;
            end else if (r < 87) begin
                cmd = CMD_TOGGLE;
            end else if (r < 96) begin
                cmd = CMD_SETPOS;
                tp  = pick_target();
            end else begin
                cmd = CMD_TILT;
            end
        end else begin
            if (r < 44) begin
                cmd = CMD_SETPOS;
                tp  = pick_target();
            end else if (r < 62) begin
                cmd = CMD_TOGGLE;
            end else if (r < 70) begin
                cmd = CMD_STOP;
            end else if (r < 80) begin
                cmd = CMD_TILT;
            end else if (r < 92) begin
                cmd = CMD_TICK;
            end else begin
                cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
            end
        end
    endtask

    // Send a fixed number of random commands; optionally squeeze the output
    task automatic run_phase(input int count, input bit squeeze);
        int          sent;
        logic [2:0]  cmd;
        logic [15:0] el;
        logic [15:0] tp;
        logic        tl;
        sent = 0;
        while (sent < count) begin
            if (squeeze && sent == count / 4) begin
                hold_request = 1'b1;
                squeeze      = 1'b0;
            end
            pick_item(cmd, el, tp, tl);
            send_command(cmd, el, tp, tl, 1'b0, 16'd0, MOT_IDLE);
            sent++;
        end
    endtask

    // Output side: random back-pressure, plus one long hold when requested
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Score each output word against the oldest booked word
    always @(posedge i_clk) begin : score_words
        t_cover_word got;
        t_cover_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = word_of(m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tlast,
                          m_axis_tdata[23:8], m_axis_tdata[25:24]);
            if (expected_frame_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_FIRST) begin
                    $display("unexpected word: has_byte=%0d byte=%h last=%0d pos=%h mot=%0d",
                             got.has_byte, got.fbyte, got.last, got.pos, got.mot);
                end
            end else begin
                want = expected_frame_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_FIRST) begin
                        $display("mismatch exp has_byte=%0d byte=%h last=%0d pos=%h mot=%0d",
                                 want.has_byte, want.fbyte, want.last, want.pos, want.mot);
                        $display("         got has_byte=%0d byte=%h last=%0d pos=%h mot=%0d",
                                 got.has_byte, got.fbyte, got.last, got.pos, got.mot);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no handshake completes for too long
    always @(posedge i_clk) begin
        if (run_active) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL timed_cover_position_frame_controller_top");
                $finish;
            end
        end
    end

    initial begin
        // Predictor state after reset
        pos_q   = POS_HALF;
        tgt_q   = 16'd0;
        mot_q   = MOT_IDLE;
        ldir_q  = MOT_IDLE;
        node_q  = '0;
        ch_q    = '0;
        open_q  = DUR_RESET;
        close_q = DUR_RESET;
        inv_q   = 1'b0;
        frm_len = 0;

        // Directed table at reset defaults
        add_row(CMD_TICK,   16'd1000,  POS_FULL,  1'b1, 1'b1, POS_HALF,  MOT_IDLE);
        add_row(CMD_RSVD5,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1, POS_HALF,  MOT_IDLE);
        add_row(CMD_RSVD6,  16'h5A5A,  16'hA5A5,  1'b0, 1'b1, POS_HALF,  MOT_IDLE);
        add_row(CMD_RSVD7,  16'd0,     16'd0,     1'b0, 1'b1, POS_HALF,  MOT_IDLE);
        add_row(CMD_SETPOS, 16'hFFFF,  POS_HALF,  1'b1, 1'b1, POS_HALF,  MOT_IDLE);
        add_row(CMD_STOP,   16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TILT,   16'd0,     16'd0,     1'b1, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TILT,   16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TOGGLE, 16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TICK,   16'd0,     16'hFFFF,  1'b1, 1'b1, POS_HALF,  MOT_CLOSE);
        add_row(CMD_TICK,   16'hFFFF,  16'd0,     1'b0, 1'b1, 16'd0,     MOT_IDLE);
        add_row(CMD_SETPOS, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TOGGLE, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TOGGLE, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_SETPOS, 16'd0,     POS_FULL,  1'b0, 1'b1, 16'd0,     MOT_OPEN);
        add_row(CMD_TICK,   16'hFFFF,  16'd0,     1'b0, 1'b1, POS_FULL,  MOT_IDLE);
        add_row(CMD_SETPOS, 16'd0,     POS_FULL,  1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_STOP,   16'd0,     16'd0,     1'b1, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_SETPOS, 16'd0,     16'h4000,  1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TICK,   16'd3000,  16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TICK,   16'd5000,  16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_SETPOS, 16'd0,     16'hBFFF,  1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TICK,   16'hFFFF,  16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_TOGGLE, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);
        add_row(CMD_STOP,   16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     MOT_IDLE);

        // Hold reset from time zero, then release it once
        repeat (2) @(negedge i_clk);
        i_rst_n    <= 1'b1;
        run_active  = 1'b1;

        foreach (directed_plan[i]) begin
            send_command(directed_plan[i].cmd, directed_plan[i].elapsed, directed_plan[i].tpos,
                         directed_plan[i].tilt, directed_plan[i].typed,
                         directed_plan[i].exp_pos, directed_plan[i].exp_mot);
        end

        // Sender sparse, receiver busy: mid-range travel times, swapped codes
        set_regs(24'($urandom), 8'($urandom), 22'($urandom_range(20000, 500)),
                 22'($urandom_range(20000, 500)), 1'b1);
        run_phase(PHASE_ITEMS, 1'b0);

        // Swap the idling; all-ones address, fastest open and slowest close
        snd_idle_pct = 51;
        rcv_idle_pct = 23;
        set_regs(24'hFFFFFF, 8'hFF, 22'd1, 22'd3600000, 1'b0);
        run_phase(PHASE_ITEMS, 1'b0);

        // No idling; zero address, zero open time behaves as one millisecond
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_regs(24'd0, 8'd0, 22'd0, 22'd1, 1'b1);
        run_phase(PHASE_ITEMS, 1'b0);

        // No idling, then a long output hold so the block backs up
        set_regs(24'($urandom), 8'($urandom), 22'($urandom_range(60000, 1000)),
                 22'($urandom_range(60000, 1000)), 1'b0);
        run_phase(PHASE_ITEMS, 1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS timed_cover_position_frame_controller_top");
        end else begin
            $display("FAIL timed_cover_position_frame_controller_top");
        end
        $finish;
    end

endmodule
